FILE: rtl/i2c_register_access_master_macros.svh
// ---------------------------------------------------------------------------
// I2C register access master - assertion macros
// Immediate-consequence and next-cycle checks with a common reset guard.
// ---------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_MACROS_SVH

// ante must imply cons in the same cycle
`define I2C_RAM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2c register access master: check failed");

// ante must imply cons in the following cycle
`define I2C_RAM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2c register access master: check failed");

`endif

FILE: rtl/i2c_ram_pkg.sv
// ---------------------------------------------------------------------------
// I2C register access master - package
// Sequencer states, request and status codes, byte roles and constants.
// ---------------------------------------------------------------------------
`default_nettype none

package i2c_ram_pkg;

   localparam int PHASE_W = 16;
   localparam int ADDR_W  = 7;
   localparam int BYTE_W  = 8;
   localparam int BITS_W  = 4;

   localparam logic [BYTE_W-1:0] BYTE_MSB  = 8'h80;
   localparam logic [BYTE_W-1:0] READ_BIT  = 8'h01;
   localparam logic [BITS_W-1:0] BYTE_BITS = 4'd8;

   typedef enum logic [24:0] {
      ST_IDLE = 25'h0000001,
      ST_S0   = 25'h0000002,
      ST_S1   = 25'h0000004,
      ST_S2   = 25'h0000008,
      ST_B0   = 25'h0000010,
      ST_B1   = 25'h0000020,
      ST_B2   = 25'h0000040,
      ST_A0   = 25'h0000080,
      ST_A1   = 25'h0000100,
      ST_A2   = 25'h0000200,
      ST_A3   = 25'h0000400,
      ST_WAIT = 25'h0000800,
      ST_Q0   = 25'h0001000,
      ST_Q1   = 25'h0002000,
      ST_Q2   = 25'h0004000,
      ST_R0   = 25'h0008000,
      ST_R1   = 25'h0010000,
      ST_K0   = 25'h0020000,
      ST_K1   = 25'h0040000,
      ST_K2   = 25'h0080000,
      ST_K3   = 25'h0100000,
      ST_P0   = 25'h0200000,
      ST_P1   = 25'h0400000,
      ST_P2   = 25'h0800000,
      ST_P3   = 25'h1000000
   } step_type;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_START = 2'd1,
      REQ_DATA  = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_BUS_BUSY  = 2'd1,
      STAT_ADDR_NACK = 2'd2,
      STAT_DATA_NACK = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ROLE_ADDR_W = 2'd0,
      ROLE_REG    = 2'd1,
      ROLE_DATA   = 2'd2,
      ROLE_ADDR_R = 2'd3
   } role_type;

   typedef enum logic {
      CSR_DEVICE_ADDRESS = 1'b0,
      CSR_PHASE_TICKS    = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

FILE: rtl/i2c_register_access_master.sv
// ---------------------------------------------------------------------------
// I2C register access master
// Open-drain burst register read/write sequencer driven by tick transfers.
// ---------------------------------------------------------------------------
// One request transfer is taken in any cycle in which the response register is
// empty or its transfer completes, so items can follow back to back at one per
// clock; the response is presented in the following cycle from an output
// register, and a stalled response stalls the request channel. Each tick
// request outside the idle and wait steps advances the phase counter by one and
// ends at most one pin phase, so a phase lasts phase_ticks tick transfers (0 acts
// as 1). Start and data requests update the sequencer without counting time. A
// write holds the clock low in the wait step until a data byte is supplied.
`default_nettype none

`include "i2c_register_access_master_macros.svh"

module i2c_register_access_master (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic        req_is_read,
   input  wire logic [7:0]  req_reg_addr,
   input  wire logic [7:0]  req_length,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_sda_in,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_scl_out,
   output logic             rsp_sda_out,
   output logic [7:0]       rsp_rd_data,
   output logic             rsp_rd_valid,
   output logic             rsp_need_data,
   output logic             rsp_done_res,
   output logic [1:0]       rsp_status,
   output logic             rsp_busy_res
);

   // configuration
   logic [i2c_ram_pkg::ADDR_W-1:0]  dev_addr_ff;
   logic [i2c_ram_pkg::PHASE_W-1:0] phase_ticks_ff;

   // sequencer state
   i2c_ram_pkg::step_type           step_ff,   step_in;
   logic [i2c_ram_pkg::PHASE_W-1:0] phase_ff,  phase_in;
   logic [i2c_ram_pkg::BYTE_W-1:0]  shift_ff,  shift_in;
   logic [i2c_ram_pkg::BITS_W-1:0]  bits_ff,   bits_in;
   logic [i2c_ram_pkg::BYTE_W-1:0]  bytes_ff,  bytes_in;
   logic [i2c_ram_pkg::BYTE_W-1:0]  hreg_ff,   hreg_in;
   logic                            rmode_ff,  rmode_in;
   logic [i2c_ram_pkg::BYTE_W:0]    pend_ff,   pend_in;
   logic [1:0]                      drive_ff,  drive_in;
   i2c_ram_pkg::status_type         lstat_ff,  lstat_in;
   i2c_ram_pkg::role_type           role_ff,   role_in;
   logic                            nack_ff,   nack_in;

   // response register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [1:0]                      rsp_drive_ff;
   logic [i2c_ram_pkg::BYTE_W-1:0]  rsp_rd_data_ff;
   logic                            rsp_rd_valid_ff;
   logic                            rsp_need_ff;
   logic                            rsp_done_ff;
   i2c_ram_pkg::status_type         rsp_status_ff;
   logic                            rsp_busy_ff;

   logic                            accept;
   logic                            got;
   logic                            fin;
   logic                            do_go;
   i2c_ram_pkg::step_type           go_tgt;
   logic [i2c_ram_pkg::PHASE_W-1:0] limit;
   logic [i2c_ram_pkg::PHASE_W-1:0] phase_sum;

   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   assign limit        = (phase_ticks_ff == '0) ? {{(i2c_ram_pkg::PHASE_W-1){1'b0}}, 1'b1}
                                                : phase_ticks_ff;
   assign phase_sum    = phase_ff + {{(i2c_ram_pkg::PHASE_W-1){1'b0}}, 1'b1};

   always_comb begin
      step_in  = step_ff;
      phase_in = phase_ff;
      shift_in = shift_ff;
      bits_in  = bits_ff;
      bytes_in = bytes_ff;
      hreg_in  = hreg_ff;
      rmode_in = rmode_ff;
      pend_in  = pend_ff;
      drive_in = drive_ff;
      lstat_in = lstat_ff;
      role_in  = role_ff;
      nack_in  = nack_ff;
      got      = 1'b0;
      fin      = 1'b0;
      do_go    = 1'b0;
      go_tgt   = i2c_ram_pkg::ST_IDLE;

      if (accept) begin
         priority if (req_type == i2c_ram_pkg::REQ_START) begin
            if (step_ff == i2c_ram_pkg::ST_IDLE) begin
               rmode_in = req_is_read;
               hreg_in  = req_reg_addr;
               bytes_in = req_length;
               pend_in  = '0;
               lstat_in = i2c_ram_pkg::STAT_OK;
               nack_in  = 1'b0;
               shift_in = '0;
               bits_in  = '0;
               do_go    = 1'b1;
               go_tgt   = i2c_ram_pkg::ST_S0;
            end
         end else if (req_type == i2c_ram_pkg::REQ_DATA) begin
            if (step_ff != i2c_ram_pkg::ST_IDLE) begin
               pend_in = {1'b1, req_data_byte};
            end
         end else if (req_type == i2c_ram_pkg::REQ_TICK &&
                      step_ff != i2c_ram_pkg::ST_IDLE) begin
            if (step_ff == i2c_ram_pkg::ST_WAIT) begin
               if (pend_ff[i2c_ram_pkg::BYTE_W]) begin
                  shift_in = pend_ff[i2c_ram_pkg::BYTE_W-1:0];
                  pend_in  = '0;
                  role_in  = i2c_ram_pkg::ROLE_DATA;
                  bits_in  = i2c_ram_pkg::BYTE_BITS;
                  do_go    = 1'b1;
                  go_tgt   = i2c_ram_pkg::ST_B0;
               end
            end else begin
               phase_in = phase_sum;
               if (phase_in >= limit || phase_in == '0) begin
                  do_go = 1'b1;
                  unique case (step_ff)
                     i2c_ram_pkg::ST_S0: begin
                        if (!req_sda_in) begin
                           lstat_in = i2c_ram_pkg::STAT_BUS_BUSY;
                           go_tgt   = i2c_ram_pkg::ST_IDLE;
                           fin      = 1'b1;
                        end else begin
                           go_tgt = i2c_ram_pkg::ST_S1;
                        end
                     end
                     i2c_ram_pkg::ST_S1: begin
                        if (req_sda_in) begin
                           lstat_in = i2c_ram_pkg::STAT_BUS_BUSY;
                           go_tgt   = i2c_ram_pkg::ST_IDLE;
                           fin      = 1'b1;
                        end else begin
                           go_tgt = i2c_ram_pkg::ST_S2;
                        end
                     end
                     i2c_ram_pkg::ST_S2: begin
                        shift_in = {dev_addr_ff, 1'b0};
                        role_in  = i2c_ram_pkg::ROLE_ADDR_W;
                        bits_in  = i2c_ram_pkg::BYTE_BITS;
                        go_tgt   = i2c_ram_pkg::ST_B0;
                     end
                     i2c_ram_pkg::ST_Q0: go_tgt = i2c_ram_pkg::ST_Q1;
                     i2c_ram_pkg::ST_Q1: go_tgt = i2c_ram_pkg::ST_Q2;
                     i2c_ram_pkg::ST_Q2: begin
                        shift_in = {dev_addr_ff, 1'b0} | i2c_ram_pkg::READ_BIT;
                        role_in  = i2c_ram_pkg::ROLE_ADDR_R;
                        bits_in  = i2c_ram_pkg::BYTE_BITS;
                        go_tgt   = i2c_ram_pkg::ST_B0;
                     end
                     i2c_ram_pkg::ST_B0: go_tgt = i2c_ram_pkg::ST_B1;
                     i2c_ram_pkg::ST_B1: go_tgt = i2c_ram_pkg::ST_B2;
                     i2c_ram_pkg::ST_B2: begin
                        bits_in = bits_ff - 4'd1;
                        go_tgt  = (bits_in != '0) ? i2c_ram_pkg::ST_B0 : i2c_ram_pkg::ST_A0;
                     end
                     i2c_ram_pkg::ST_A0: go_tgt = i2c_ram_pkg::ST_A1;
                     i2c_ram_pkg::ST_A1: go_tgt = i2c_ram_pkg::ST_A2;
                     i2c_ram_pkg::ST_A2: begin
                        nack_in = req_sda_in;
                        go_tgt  = i2c_ram_pkg::ST_A3;
                     end
                     i2c_ram_pkg::ST_A3: begin
                        unique case (role_ff)
                           i2c_ram_pkg::ROLE_ADDR_W: begin
                              if (nack_ff) begin
                                 lstat_in = i2c_ram_pkg::STAT_ADDR_NACK;
                                 go_tgt   = i2c_ram_pkg::ST_P0;
                              end else begin
                                 shift_in = hreg_ff;
                                 role_in  = i2c_ram_pkg::ROLE_REG;
                                 bits_in  = i2c_ram_pkg::BYTE_BITS;
                                 go_tgt   = i2c_ram_pkg::ST_B0;
                              end
                           end
                           i2c_ram_pkg::ROLE_REG: begin
                              if (rmode_ff) begin
                                 go_tgt = i2c_ram_pkg::ST_Q0;
                              end else if (bytes_ff == '0) begin
                                 lstat_in = i2c_ram_pkg::STAT_OK;
                                 go_tgt   = i2c_ram_pkg::ST_P0;
                              end else begin
                                 go_tgt = i2c_ram_pkg::ST_WAIT;
                              end
                           end
                           i2c_ram_pkg::ROLE_DATA: begin
                              if (nack_ff) begin
                                 lstat_in = i2c_ram_pkg::STAT_DATA_NACK;
                                 go_tgt   = i2c_ram_pkg::ST_P0;
                              end else begin
                                 bytes_in = bytes_ff - 8'd1;
                                 if (bytes_in == '0) begin
                                    lstat_in = i2c_ram_pkg::STAT_OK;
                                    go_tgt   = i2c_ram_pkg::ST_P0;
                                 end else begin
                                    go_tgt = i2c_ram_pkg::ST_WAIT;
                                 end
                              end
                           end
                           i2c_ram_pkg::ROLE_ADDR_R: begin
                              if (bytes_ff == '0) begin
                                 lstat_in = i2c_ram_pkg::STAT_OK;
                                 go_tgt   = i2c_ram_pkg::ST_P0;
                              end else begin
                                 shift_in = '0;
                                 bits_in  = i2c_ram_pkg::BYTE_BITS;
                                 go_tgt   = i2c_ram_pkg::ST_R0;
                              end
                           end
                        endcase
                     end
                     i2c_ram_pkg::ST_R0: go_tgt = i2c_ram_pkg::ST_R1;
                     i2c_ram_pkg::ST_R1: begin
                        shift_in = {shift_ff[i2c_ram_pkg::BYTE_W-2:0], req_sda_in};
                        bits_in  = bits_ff - 4'd1;
                        if (bits_in != '0) begin
                           go_tgt = i2c_ram_pkg::ST_R0;
                        end else begin
                           got    = 1'b1;
                           go_tgt = i2c_ram_pkg::ST_K0;
                        end
                     end
                     i2c_ram_pkg::ST_K0: go_tgt = i2c_ram_pkg::ST_K1;
                     i2c_ram_pkg::ST_K1: go_tgt = i2c_ram_pkg::ST_K2;
                     i2c_ram_pkg::ST_K2: go_tgt = i2c_ram_pkg::ST_K3;
                     i2c_ram_pkg::ST_K3: begin
                        bytes_in = bytes_ff - 8'd1;
                        if (bytes_in == '0) begin
                           lstat_in = i2c_ram_pkg::STAT_OK;
                           go_tgt   = i2c_ram_pkg::ST_P0;
                        end else begin
                           shift_in = '0;
                           bits_in  = i2c_ram_pkg::BYTE_BITS;
                           go_tgt   = i2c_ram_pkg::ST_R0;
                        end
                     end
                     i2c_ram_pkg::ST_P0: go_tgt = i2c_ram_pkg::ST_P1;
                     i2c_ram_pkg::ST_P1: go_tgt = i2c_ram_pkg::ST_P2;
                     i2c_ram_pkg::ST_P2: go_tgt = i2c_ram_pkg::ST_P3;
                     i2c_ram_pkg::ST_P3: begin
                        go_tgt = i2c_ram_pkg::ST_IDLE;
                        fin    = 1'b1;
                     end
                     default: go_tgt = i2c_ram_pkg::ST_IDLE;
                  endcase
               end
            end
         end else begin
            // unused code, or a tick while idle
            do_go = 1'b0;
         end
      end

      // entry actions of the step being entered
      if (do_go) begin
         step_in  = go_tgt;
         phase_in = '0;
         unique case (go_tgt)
            i2c_ram_pkg::ST_IDLE, i2c_ram_pkg::ST_S0, i2c_ram_pkg::ST_Q0:
               drive_in = 2'b11;
            i2c_ram_pkg::ST_S1, i2c_ram_pkg::ST_Q1, i2c_ram_pkg::ST_P1:
               drive_in[0] = 1'b0;
            i2c_ram_pkg::ST_B1: begin
               drive_in = {1'b0, (shift_in & i2c_ram_pkg::BYTE_MSB) != '0};
               shift_in = {shift_in[i2c_ram_pkg::BYTE_W-2:0], 1'b0};
            end
            i2c_ram_pkg::ST_A1, i2c_ram_pkg::ST_P3:
               drive_in[0] = 1'b1;
            i2c_ram_pkg::ST_R0:
               drive_in = 2'b01;
            i2c_ram_pkg::ST_K1:
               drive_in[0] = (bytes_in == 8'd1);
            i2c_ram_pkg::ST_B2, i2c_ram_pkg::ST_A2, i2c_ram_pkg::ST_R1,
            i2c_ram_pkg::ST_K2, i2c_ram_pkg::ST_P2:
               drive_in[1] = 1'b1;
            i2c_ram_pkg::ST_B0, i2c_ram_pkg::ST_A0, i2c_ram_pkg::ST_A3,
            i2c_ram_pkg::ST_WAIT, i2c_ram_pkg::ST_K0, i2c_ram_pkg::ST_K3,
            i2c_ram_pkg::ST_P0:
               drive_in[1] = 1'b0;
            default:
               drive_in = drive_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff    <= '0;
         phase_ticks_ff <= 16'd1;
      end else if (csr_we) begin
         unique case (i2c_ram_pkg::csr_index_type'(csr_index))
            i2c_ram_pkg::CSR_DEVICE_ADDRESS: dev_addr_ff    <= csr_wdata[i2c_ram_pkg::ADDR_W-1:0];
            i2c_ram_pkg::CSR_PHASE_TICKS:    phase_ticks_ff <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= i2c_ram_pkg::ST_IDLE;
         phase_ff     <= '0;
         shift_ff     <= '0;
         bits_ff      <= '0;
         bytes_ff     <= '0;
         hreg_ff      <= '0;
         rmode_ff     <= 1'b0;
         pend_ff      <= '0;
         drive_ff     <= 2'b11;
         lstat_ff     <= i2c_ram_pkg::STAT_OK;
         role_ff      <= i2c_ram_pkg::ROLE_ADDR_W;
         nack_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         shift_ff     <= shift_in;
         bits_ff      <= bits_in;
         bytes_ff     <= bytes_in;
         hreg_ff      <= hreg_in;
         rmode_ff     <= rmode_in;
         pend_ff      <= pend_in;
         drive_ff     <= drive_in;
         lstat_ff     <= lstat_in;
         role_ff      <= role_in;
         nack_ff      <= nack_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_drive_ff    <= drive_in;
         rsp_rd_data_ff  <= got ? shift_in : '0;
         rsp_rd_valid_ff <= got;
         rsp_need_ff     <= (step_in == i2c_ram_pkg::ST_WAIT);
         rsp_done_ff     <= fin;
         rsp_status_ff   <= lstat_in;
         rsp_busy_ff     <= (step_in != i2c_ram_pkg::ST_IDLE);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_out   = rsp_drive_ff[1];
   assign rsp_sda_out   = rsp_drive_ff[0];
   assign rsp_rd_data   = rsp_rd_data_ff;
   assign rsp_rd_valid  = rsp_rd_valid_ff;
   assign rsp_need_data = rsp_need_ff;
   assign rsp_done_res  = rsp_done_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_busy_res  = rsp_busy_ff;

   // clock held low while a write waits for data; both lines free when idle
   `I2C_RAM_ASSERT_IMPL(a_wait_scl_low, clock, reset,
      step_ff == i2c_ram_pkg::ST_WAIT, drive_ff[1] == 1'b0)
   `I2C_RAM_ASSERT_IMPL(a_idle_released, clock, reset,
      step_ff == i2c_ram_pkg::ST_IDLE, drive_ff == 2'b11)
   `I2C_RAM_ASSERT_NEXT(a_start_taken, clock, reset,
      accept && req_type == i2c_ram_pkg::REQ_START && step_ff == i2c_ram_pkg::ST_IDLE,
      step_ff == i2c_ram_pkg::ST_S0 && rsp_valid_ff && rsp_busy_ff)
   `I2C_RAM_ASSERT_IMPL(a_rd_byte_busy, clock, reset,
      rsp_valid_ff && rsp_rd_valid_ff, rsp_busy_ff && !rsp_done_ff)

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb - I2C register access master
// A generator keeps its own copy of the sequencer so that it can act as a
// plausible slave. It builds start, tick and write-byte requests, and the SDA
// level it samples follows the bus phase: a free or busy bus at start, acks or
// nacks on address and data, and random read bits. Random noise items are mixed
// in. A clocked driver and a clocked monitor move the transfers with random
// idling and stalls. Every response is checked field by field against a
// prediction made when its request is accepted. The run covers several device
// addresses and phase lengths, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   typedef struct {
      i2c_ram_pkg::req_code_type kind;
      logic                      is_read;
      logic [7:0]                reg_addr;
      logic [7:0]                length;
      logic [7:0]                data_byte;
      logic                      sda_in;
   } bus_req_type;

   typedef struct {
      logic                    scl;
      logic                    sda;
      logic [7:0]              rd_data;
      logic                    rd_valid;
      logic                    need_data;
      logic                    done;
      i2c_ram_pkg::status_type status;
      logic                    busy;
   } bus_rsp_type;

   typedef struct {
      i2c_ram_pkg::step_type   step;
      logic [15:0]             phase_count;
      logic [7:0]              shift;
      logic [3:0]              bits;
      logic [7:0]              left;
      logic [7:0]              held_reg;
      logic                    rd_mode;
      logic                    pend_valid;
      logic [7:0]              pend_data;
      logic                    scl;
      logic                    sda;
      i2c_ram_pkg::status_type status;
      i2c_ram_pkg::role_type   role;
      logic                    nack;
      logic [6:0]              dev_addr;
      logic [15:0]             ticks;
   } seq_state_type;

   typedef enum {
      FAULT_NONE, FAULT_BUSY_START, FAULT_BUSY_LOW, FAULT_ADDR_NACK, FAULT_DATA_NACK
   } fault_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = '0;
   logic        req_is_read = 1'b0;
   logic [7:0]  req_reg_addr = '0;
   logic [7:0]  req_length = '0;
   logic [7:0]  req_data_byte = '0;
   logic        req_sda_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_scl_out;
   logic        rsp_sda_out;
   logic [7:0]  rsp_rd_data;
   logic        rsp_rd_valid;
   logic        rsp_need_data;
   logic        rsp_done_res;
   logic [1:0]  rsp_status;
   logic        rsp_busy_res;

   bus_req_type   req_backlog[$];
   bus_rsp_type   rsp_expected[$];
   seq_state_type gen_state;
   seq_state_type chk_state;
   bus_req_type   req_now;
   int            req_gap = 0;
   int            rsp_hold = 0;
   bit            req_calm = 1'b0;
   bit            rsp_calm = 1'b0;
   bit            fast_mode = 1'b0;
   int            pushed_total = 0;
   int            counted_items = 0;
   int            rsp_checked = 0;
   int            error_count = 0;
   int            rd_bytes = 0;
   int            txn_started = 0;
   int            status_seen[4] = '{0, 0, 0, 0};

   i2c_register_access_master dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_is_read   (req_is_read),
      .req_reg_addr  (req_reg_addr),
      .req_length    (req_length),
      .req_data_byte (req_data_byte),
      .req_sda_in    (req_sda_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_scl_out   (rsp_scl_out),
      .rsp_sda_out   (rsp_sda_out),
      .rsp_rd_data   (rsp_rd_data),
      .rsp_rd_valid  (rsp_rd_valid),
      .rsp_need_data (rsp_need_data),
      .rsp_done_res  (rsp_done_res),
      .rsp_status    (rsp_status),
      .rsp_busy_res  (rsp_busy_res)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // --- sequencer prediction -------------------------------------------------

   function automatic seq_state_type reset_state();
      seq_state_type m;
      m.step        = i2c_ram_pkg::ST_IDLE;
      m.phase_count = '0;
      m.shift       = '0;
      m.bits        = '0;
      m.left        = '0;
      m.held_reg    = '0;
      m.rd_mode     = 1'b0;
      m.pend_valid  = 1'b0;
      m.pend_data   = '0;
      m.scl         = 1'b1;
      m.sda         = 1'b1;
      m.status      = i2c_ram_pkg::STAT_OK;
      m.role        = i2c_ram_pkg::ROLE_ADDR_W;
      m.nack        = 1'b0;
      m.dev_addr    = '0;
      m.ticks       = 16'd1;
      return m;
   endfunction

   function automatic void enter_step(inout seq_state_type m,
                                      input i2c_ram_pkg::step_type s);
      m.step        = s;
      m.phase_count = '0;
      case (s)
         i2c_ram_pkg::ST_IDLE, i2c_ram_pkg::ST_S0, i2c_ram_pkg::ST_Q0: begin
            m.scl = 1'b1;
            m.sda = 1'b1;
         end
         i2c_ram_pkg::ST_S1, i2c_ram_pkg::ST_Q1, i2c_ram_pkg::ST_P1: m.sda = 1'b0;
         i2c_ram_pkg::ST_B1: begin
            m.scl   = 1'b0;
            m.sda   = m.shift[7];
            m.shift = {m.shift[6:0], 1'b0};
         end
         i2c_ram_pkg::ST_A1, i2c_ram_pkg::ST_P3: m.sda = 1'b1;
         i2c_ram_pkg::ST_R0: begin
            m.scl = 1'b0;
            m.sda = 1'b1;
         end
         i2c_ram_pkg::ST_K1: m.sda = (m.left == 8'd1);
         i2c_ram_pkg::ST_B2, i2c_ram_pkg::ST_A2, i2c_ram_pkg::ST_R1,
         i2c_ram_pkg::ST_K2, i2c_ram_pkg::ST_P2: m.scl = 1'b1;
         i2c_ram_pkg::ST_B0, i2c_ram_pkg::ST_A0, i2c_ram_pkg::ST_A3,
         i2c_ram_pkg::ST_WAIT, i2c_ram_pkg::ST_K0, i2c_ram_pkg::ST_K3,
         i2c_ram_pkg::ST_P0: m.scl = 1'b0;
         default: ;
      endcase
   endfunction

   function automatic void load_byte(inout seq_state_type m, input logic [7:0] value,
                                     input i2c_ram_pkg::role_type role);
      m.shift = value;
      m.role  = role;
      m.bits  = i2c_ram_pkg::BYTE_BITS;
      enter_step(m, i2c_ram_pkg::ST_B0);
   endfunction

   function automatic void stop_with(inout seq_state_type m,
                                     input i2c_ram_pkg::status_type st);
      m.status = st;
      enter_step(m, i2c_ram_pkg::ST_P0);
   endfunction

   function automatic void start_rx_byte(inout seq_state_type m);
      m.shift = '0;
      m.bits  = i2c_ram_pkg::BYTE_BITS;
      enter_step(m, i2c_ram_pkg::ST_R0);
   endfunction

   function automatic void ack_done(inout seq_state_type m);
      case (m.role)
         i2c_ram_pkg::ROLE_ADDR_W: begin
            if (m.nack) stop_with(m, i2c_ram_pkg::STAT_ADDR_NACK);
            else load_byte(m, m.held_reg, i2c_ram_pkg::ROLE_REG);
         end
         i2c_ram_pkg::ROLE_REG: begin
            if (m.rd_mode) enter_step(m, i2c_ram_pkg::ST_Q0);
            else if (m.left == 0) stop_with(m, i2c_ram_pkg::STAT_OK);
            else enter_step(m, i2c_ram_pkg::ST_WAIT);
         end
         i2c_ram_pkg::ROLE_DATA: begin
            if (m.nack) begin
               stop_with(m, i2c_ram_pkg::STAT_DATA_NACK);
            end else begin
               m.left = m.left - 8'd1;
               if (m.left == 0) stop_with(m, i2c_ram_pkg::STAT_OK);
               else enter_step(m, i2c_ram_pkg::ST_WAIT);
            end
         end
         default: begin
            if (m.left == 0) stop_with(m, i2c_ram_pkg::STAT_OK);
            else start_rx_byte(m);
         end
      endcase
   endfunction

   function automatic void close_phase(inout seq_state_type m, input logic sda,
                                       inout logic got, inout logic fin);
      case (m.step)
         i2c_ram_pkg::ST_S0: begin
            if (!sda) begin
               m.status = i2c_ram_pkg::STAT_BUS_BUSY;
               enter_step(m, i2c_ram_pkg::ST_IDLE);
               fin = 1'b1;
            end else begin
               enter_step(m, i2c_ram_pkg::ST_S1);
            end
         end
         i2c_ram_pkg::ST_S1: begin
            if (sda) begin
               m.status = i2c_ram_pkg::STAT_BUS_BUSY;
               enter_step(m, i2c_ram_pkg::ST_IDLE);
               fin = 1'b1;
            end else begin
               enter_step(m, i2c_ram_pkg::ST_S2);
            end
         end
         i2c_ram_pkg::ST_S2:
            load_byte(m, {m.dev_addr, 1'b0}, i2c_ram_pkg::ROLE_ADDR_W);
         i2c_ram_pkg::ST_Q0: enter_step(m, i2c_ram_pkg::ST_Q1);
         i2c_ram_pkg::ST_Q1: enter_step(m, i2c_ram_pkg::ST_Q2);
         i2c_ram_pkg::ST_Q2:
            load_byte(m, {m.dev_addr, 1'b0} | i2c_ram_pkg::READ_BIT,
                      i2c_ram_pkg::ROLE_ADDR_R);
         i2c_ram_pkg::ST_B0: enter_step(m, i2c_ram_pkg::ST_B1);
         i2c_ram_pkg::ST_B1: enter_step(m, i2c_ram_pkg::ST_B2);
         i2c_ram_pkg::ST_B2: begin
            m.bits = m.bits - 4'd1;
            enter_step(m, (m.bits != 0) ? i2c_ram_pkg::ST_B0 : i2c_ram_pkg::ST_A0);
         end
         i2c_ram_pkg::ST_A0: enter_step(m, i2c_ram_pkg::ST_A1);
         i2c_ram_pkg::ST_A1: enter_step(m, i2c_ram_pkg::ST_A2);
         i2c_ram_pkg::ST_A2: begin
            m.nack = sda;
            enter_step(m, i2c_ram_pkg::ST_A3);
         end
         i2c_ram_pkg::ST_A3: ack_done(m);
         i2c_ram_pkg::ST_R0: enter_step(m, i2c_ram_pkg::ST_R1);
         i2c_ram_pkg::ST_R1: begin
            m.shift = {m.shift[6:0], sda};
            m.bits  = m.bits - 4'd1;
            if (m.bits != 0) begin
               enter_step(m, i2c_ram_pkg::ST_R0);
            end else begin
               got = 1'b1;
               enter_step(m, i2c_ram_pkg::ST_K0);
            end
         end
         i2c_ram_pkg::ST_K0: enter_step(m, i2c_ram_pkg::ST_K1);
         i2c_ram_pkg::ST_K1: enter_step(m, i2c_ram_pkg::ST_K2);
         i2c_ram_pkg::ST_K2: enter_step(m, i2c_ram_pkg::ST_K3);
         i2c_ram_pkg::ST_K3: begin
            m.left = m.left - 8'd1;
            if (m.left == 0) stop_with(m, i2c_ram_pkg::STAT_OK);
            else start_rx_byte(m);
         end
         i2c_ram_pkg::ST_P0: enter_step(m, i2c_ram_pkg::ST_P1);
         i2c_ram_pkg::ST_P1: enter_step(m, i2c_ram_pkg::ST_P2);
         i2c_ram_pkg::ST_P2: enter_step(m, i2c_ram_pkg::ST_P3);
         i2c_ram_pkg::ST_P3: begin
            enter_step(m, i2c_ram_pkg::ST_IDLE);
            fin = 1'b1;
         end
         default: enter_step(m, i2c_ram_pkg::ST_IDLE);
      endcase
   endfunction

   function automatic bus_rsp_type predict_bus_step(inout seq_state_type m,
                                                    input bus_req_type it);
      bus_rsp_type r;
      logic        got;
      logic        fin;
      logic [15:0] lim;
      logic [7:0]  b;
      got = 1'b0;
      fin = 1'b0;
      case (it.kind)
         i2c_ram_pkg::REQ_START: begin
            if (m.step == i2c_ram_pkg::ST_IDLE) begin
               m.rd_mode    = it.is_read;
               m.held_reg   = it.reg_addr;
               m.left       = it.length;
               m.pend_valid = 1'b0;
               m.pend_data  = '0;
               m.status     = i2c_ram_pkg::STAT_OK;
               m.nack       = 1'b0;
               m.shift      = '0;
               m.bits       = '0;
               enter_step(m, i2c_ram_pkg::ST_S0);
            end
         end
         i2c_ram_pkg::REQ_DATA: begin
            if (m.step != i2c_ram_pkg::ST_IDLE) begin
               m.pend_valid = 1'b1;
               m.pend_data  = it.data_byte;
            end
         end
         i2c_ram_pkg::REQ_TICK: begin
            if (m.step == i2c_ram_pkg::ST_WAIT) begin
               if (m.pend_valid) begin
                  b            = m.pend_data;
                  m.pend_valid = 1'b0;
                  m.pend_data  = '0;
                  load_byte(m, b, i2c_ram_pkg::ROLE_DATA);
               end
            end else if (m.step != i2c_ram_pkg::ST_IDLE) begin
               lim           = (m.ticks == 0) ? 16'd1 : m.ticks;
               m.phase_count = m.phase_count + 16'd1;
               if (m.phase_count >= lim || m.phase_count == 0)
                  close_phase(m, it.sda_in, got, fin);
            end
         end
         default: ;
      endcase
      r.scl       = m.scl;
      r.sda       = m.sda;
      r.rd_data   = got ? m.shift : 8'h00;
      r.rd_valid  = got;
      r.need_data = (m.step == i2c_ram_pkg::ST_WAIT);
      r.done      = fin;
      r.status    = m.status;
      r.busy      = (m.step != i2c_ram_pkg::ST_IDLE);
      return r;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] actual);
      if (want !== actual) begin
         error_count++;
         if (error_count <= 100) $error("%s: expected %0h, got %0h", name, want, actual);
      end
   endfunction

   // --- driver and monitor ---------------------------------------------------

   always @(posedge clock) begin : req_driver
      bus_rsp_type exp_r;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            exp_r = predict_bus_step(chk_state, req_now);
            rsp_expected.push_back(exp_r);
         end
         if (!req_valid || !req_stall) begin
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               req_now = req_backlog.pop_front();
               req_valid     <= 1'b1;
               req_type      <= req_now.kind;
               req_is_read   <= req_now.is_read;
               req_reg_addr  <= req_now.reg_addr;
               req_length    <= req_now.length;
               req_data_byte <= req_now.data_byte;
               req_sda_in    <= req_now.sda_in;
               if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
               req_gap = (fast_mode || req_calm) ? 0 : $urandom_range(0, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      bus_rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_checked++;
            if (rsp_rd_valid === 1'b1) rd_bytes++;
            if (rsp_done_res === 1'b1) status_seen[rsp_status]++;
            if (rsp_expected.size() == 0) begin
               error_count++;
               if (error_count <= 100) $error("response transfer with no request waiting");
            end else begin
               e = rsp_expected.pop_front();
               check_field("scl_out", 8'(e.scl), 8'(rsp_scl_out));
               check_field("sda_out", 8'(e.sda), 8'(rsp_sda_out));
               check_field("rd_data", e.rd_data, rsp_rd_data);
               check_field("rd_valid", 8'(e.rd_valid), 8'(rsp_rd_valid));
               check_field("need_data", 8'(e.need_data), 8'(rsp_need_data));
               check_field("done_res", 8'(e.done), 8'(rsp_done_res));
               check_field("status", 8'(e.status), 8'(rsp_status));
               check_field("busy_res", 8'(e.busy), 8'(rsp_busy_res));
            end
            if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
            rsp_hold = (fast_mode || rsp_calm) ? 0 : $urandom_range(0, 3);
         end else if (rsp_hold != 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   // --- stimulus -------------------------------------------------------------

   function automatic bus_req_type make_req(i2c_ram_pkg::req_code_type k, logic sda);
      bus_req_type it;
      it.kind      = k;
      it.is_read   = 1'($urandom);
      it.reg_addr  = 8'($urandom);
      it.length    = 8'($urandom);
      it.data_byte = 8'($urandom);
      it.sda_in    = sda;
      return it;
   endfunction

   function automatic void gen_push(bus_req_type it, bit counted);
      void'(predict_bus_step(gen_state, it));
      req_backlog.push_back(it);
      pushed_total++;
      if (counted) counted_items++;
   endfunction

   function automatic bus_req_type noise_req();
      case ($urandom_range(0, 2))
         0:       return make_req(i2c_ram_pkg::REQ_NONE, 1'($urandom));
         1:       return make_req(i2c_ram_pkg::REQ_START, 1'($urandom));
         default: return make_req(i2c_ram_pkg::REQ_DATA, 1'($urandom));
      endcase
   endfunction

   function automatic void run_transaction(logic rd, logic [7:0] len, fault_type fault);
      bus_req_type it;
      it         = make_req(i2c_ram_pkg::REQ_START, 1'($urandom));
      it.is_read = rd;
      it.length  = len;
      gen_push(it, 1'b1);
      txn_started++;
      while (gen_state.step != i2c_ram_pkg::ST_IDLE) begin
         if ($urandom_range(0, 29) == 0) begin
            it = noise_req();
         end else if (gen_state.step == i2c_ram_pkg::ST_WAIT && !gen_state.pend_valid &&
                      $urandom_range(0, 3) != 0) begin
            it = make_req(i2c_ram_pkg::REQ_DATA, 1'($urandom));
         end else begin
            it = make_req(i2c_ram_pkg::REQ_TICK, 1'($urandom));
            case (gen_state.step)
               i2c_ram_pkg::ST_S0: it.sda_in = (fault != FAULT_BUSY_START);
               i2c_ram_pkg::ST_S1: it.sda_in = (fault == FAULT_BUSY_LOW);
               i2c_ram_pkg::ST_A2: begin
                  if (gen_state.role == i2c_ram_pkg::ROLE_ADDR_W)
                     it.sda_in = (fault == FAULT_ADDR_NACK);
                  else if (gen_state.role == i2c_ram_pkg::ROLE_DATA)
                     it.sda_in = (fault == FAULT_DATA_NACK) || ($urandom_range(0, 7) == 0);
               end
               default: ;
            endcase
         end
         gen_push(it, 1'b1);
      end
   endfunction

   function automatic void random_traffic(int n);
      int first;
      int pick;
      first = counted_items;
      while (counted_items - first < n) begin
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 1) == 0)
                  gen_push(make_req(i2c_ram_pkg::REQ_TICK, 1'($urandom)), 1'b0);
               else if ($urandom_range(0, 1) == 0)
                  gen_push(make_req(i2c_ram_pkg::REQ_NONE, 1'($urandom)), 1'b0);
               else
                  gen_push(make_req(i2c_ram_pkg::REQ_DATA, 1'($urandom)), 1'b0);
            end
         end
         pick = $urandom_range(0, 99);
         if (pick < 5) run_transaction(1'($urandom), 8'($urandom), FAULT_ADDR_NACK);
         else if (pick < 10) run_transaction(1'($urandom), 8'($urandom), FAULT_BUSY_START);
         else if (pick < 15) run_transaction(1'($urandom), 8'($urandom), FAULT_BUSY_LOW);
         else if ($urandom_range(0, 9) < 7)
            run_transaction(1'($urandom), 8'($urandom_range(0, 3)), FAULT_NONE);
         else
            run_transaction(1'($urandom), 8'($urandom_range(4, 8)), FAULT_NONE);
      end
   endfunction

   task automatic settle();
      while (rsp_checked < pushed_total) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(i2c_ram_pkg::csr_index_type idx, logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == i2c_ram_pkg::CSR_DEVICE_ADDRESS) begin
         gen_state.dev_addr = value[6:0];
         chk_state.dev_addr = value[6:0];
      end else begin
         gen_state.ticks = value;
         chk_state.ticks = value;
      end
   endtask

   initial begin : stimulus
      bus_req_type it;
      logic [15:0] v;
      gen_state = reset_state();
      chk_state = reset_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      v      = 16'($urandom);
      v[6:0] = 7'h00;
      write_csr(i2c_ram_pkg::CSR_DEVICE_ADDRESS, v);
      write_csr(i2c_ram_pkg::CSR_PHASE_TICKS, 16'd1);

      // idle items, start ignored while busy, both bus-busy aborts
      gen_push(make_req(i2c_ram_pkg::REQ_TICK, 1'b1), 1'b1);
      gen_push(make_req(i2c_ram_pkg::REQ_NONE, 1'b0), 1'b1);
      it           = make_req(i2c_ram_pkg::REQ_DATA, 1'b0);
      it.data_byte = 8'hFF;
      gen_push(it, 1'b1);
      it          = make_req(i2c_ram_pkg::REQ_START, 1'b1);
      it.is_read  = 1'b0;
      it.reg_addr = 8'hFF;
      it.length   = 8'hFF;
      gen_push(it, 1'b1);
      it         = make_req(i2c_ram_pkg::REQ_START, 1'b0);
      it.is_read = 1'b1;
      gen_push(it, 1'b1);
      gen_push(make_req(i2c_ram_pkg::REQ_NONE, 1'b1), 1'b1);
      gen_push(make_req(i2c_ram_pkg::REQ_TICK, 1'b0), 1'b1);
      gen_push(make_req(i2c_ram_pkg::REQ_TICK, 1'b0), 1'b1);
      it          = make_req(i2c_ram_pkg::REQ_START, 1'b0);
      it.is_read  = 1'b1;
      it.reg_addr = 8'h00;
      it.length   = 8'h00;
      gen_push(it, 1'b1);
      gen_push(make_req(i2c_ram_pkg::REQ_TICK, 1'b1), 1'b1);
      gen_push(make_req(i2c_ram_pkg::REQ_TICK, 1'b1), 1'b1);
      it           = make_req(i2c_ram_pkg::REQ_DATA, 1'b1);
      it.data_byte = 8'h00;
      gen_push(it, 1'b1);

      run_transaction(1'b0, 8'd0, FAULT_NONE);
      run_transaction(1'b1, 8'd0, FAULT_NONE);
      run_transaction(1'b0, 8'd2, FAULT_ADDR_NACK);
      random_traffic(100);
      settle();

      v      = 16'($urandom);
      v[6:0] = 7'h7F;
      write_csr(i2c_ram_pkg::CSR_DEVICE_ADDRESS, v);
      write_csr(i2c_ram_pkg::CSR_PHASE_TICKS, 16'd0);
      run_transaction(1'b0, 8'd255, FAULT_DATA_NACK);
      random_traffic(40);
      settle();

      write_csr(i2c_ram_pkg::CSR_DEVICE_ADDRESS, 16'($urandom));
      write_csr(i2c_ram_pkg::CSR_PHASE_TICKS, 16'd2);
      random_traffic(50);
      settle();

      // longest phase: a start and the first ticks of its first phase
      fast_mode = 1'b1;
      write_csr(i2c_ram_pkg::CSR_PHASE_TICKS, 16'hFFFF);
      gen_push(make_req(i2c_ram_pkg::REQ_START, 1'b1), 1'b1);
      repeat (16) gen_push(make_req(i2c_ram_pkg::REQ_TICK, 1'b1), 1'b1);
      settle();
      fast_mode = 1'b0;

      while (rsp_checked < pushed_total) @(posedge clock);
      repeat (8) @(posedge clock);
      if (rsp_expected.size() != 0) begin
         error_count++;
         $error("%0d responses never arrived", rsp_expected.size());
      end
      $display("Covered %0d request transfers, %0d transactions started, %0d bytes read back",
               pushed_total, txn_started, rd_bytes);
      $display("Endings seen: %0d ok, %0d bus busy, %0d address nack, %0d data nack",
               status_seen[i2c_ram_pkg::STAT_OK], status_seen[i2c_ram_pkg::STAT_BUS_BUSY],
               status_seen[i2c_ram_pkg::STAT_ADDR_NACK],
               status_seen[i2c_ram_pkg::STAT_DATA_NACK]);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/i2c_ram_pkg.sv
rtl/i2c_register_access_master.sv
dv/tb.sv
